[rtl/pixel_replicate_upscaler_core_defines.svh]
// assertion macros for the upscaler rtl
`ifndef PIXEL_REPLICATE_UPSCALER_CORE_DEFINES_SVH
`define PIXEL_REPLICATE_UPSCALER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define PRU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PRU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/pru_pkg.sv]
// shared types and constants of the pixel replicate upscaler
`timescale 1ns / 1ps
package pru_pkg;

   localparam int SCALE_W  = 7;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 16;
   localparam int PIX_W    = 24;
   localparam int KIND_W   = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [SCALE_W-1:0] MAX_FACTOR = 7'd100;
   localparam logic [7:0]         PAD_BYTE   = 8'h00;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_PULL = 1'b1;

   localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAD     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd3;

   localparam logic [1:0] REG_SCALE  = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   typedef struct packed {
      logic [SCALE_W-1:0]  scale;
      logic [WIDTH_W-1:0]  width;
      logic [HEIGHT_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              line_end;
      logic              image_end;
   } rsp_meta_type;

endpackage

[rtl/pru_line_store.sv]
// one-row pixel line store, one write and one registered read port
`timescale 1ns / 1ps
module pru_line_store
   import pru_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic rd_en,
   input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rd_addr,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem [MAX_WIDTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pru_ctrl.sv]
// fill and emission counters, line store access and first result stage
`timescale 1ns / 1ps
`include "pixel_replicate_upscaler_core_defines.svh"
module pru_ctrl
   import pru_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [PIX_W-1:0] req_tdata,
   input  logic req_tuser,
   input  logic s1_take,
   output logic s1_valid,
   output rsp_meta_type s1_meta,
   output logic mem_wr_en,
   output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] mem_wr_addr,
   output logic [PIX_W-1:0] mem_wr_data,
   output logic mem_rd_en,
   output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] mem_rd_addr
);

   localparam int FILL_W = $clog2(MAX_WIDTH + 1);
   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CNT_W  = (FILL_W > WIDTH_W) ? FILL_W : WIDTH_W;
   localparam logic [CNT_W-1:0] MAX_W_CNT = CNT_W'(MAX_WIDTH);

   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   col_ff, col_in;
   logic                emitting_ff, emitting_in;
   logic [SCALE_W-1:0]  hrep_ff, hrep_in;
   logic [SCALE_W-1:0]  vrep_ff, vrep_in;
   logic [1:0]          pad_ff, pad_in;
   logic [HEIGHT_W-1:0] rows_ff, rows_in;
   logic                s1_valid_ff, s1_valid_in;
   rsp_meta_type        s1_meta_ff, s1_meta_in;

   logic [CNT_W-1:0]    width_raw, width_eff;
   logic [SCALE_W-1:0]  scale_eff;
   logic [HEIGHT_W-1:0] height_eff;
   logic [3:0]          pad_prod;
   logic [1:0]          pad_need;
   logic                acc, acc_load, acc_pull, is_pix;

   always_comb begin
      width_raw = CNT_W'(cfg.width);
      if (width_raw == '0) begin
         width_eff = CNT_W'(1);
      end else if (width_raw > MAX_W_CNT) begin
         width_eff = MAX_W_CNT;
      end else begin
         width_eff = width_raw;
      end
      if (cfg.scale == '0) begin
         scale_eff = SCALE_W'(1);
      end else if (cfg.scale > MAX_FACTOR) begin
         scale_eff = MAX_FACTOR;
      end else begin
         scale_eff = cfg.scale;
      end
      height_eff = (cfg.height == '0) ? HEIGHT_W'(1) : cfg.height;
      // 3 bytes per pixel: pad bytes equal (width * factor) mod 4
      pad_prod = {2'b00, width_eff[1:0]} * {2'b00, scale_eff[1:0]};
      pad_need = pad_prod[1:0];
   end

   assign req_tready = !s1_valid_ff || s1_take;
   assign acc        = req_tvalid && req_tready;
   assign acc_load   = acc && (req_tuser == FUNC_LOAD);
   assign acc_pull   = acc && (req_tuser == FUNC_PULL);
   assign is_pix     = CNT_W'(col_ff) < width_eff;

   always_comb begin
      logic [FILL_W-1:0]   fill_nxt;
      logic [FILL_W-1:0]   col_nxt;
      logic [SCALE_W:0]    h_nxt;
      logic [SCALE_W:0]    v_nxt;
      logic [2:0]          p_nxt;
      logic [HEIGHT_W:0]   r_nxt;
      logic                le;
      logic                produce;

      fill_in     = fill_ff;
      col_in      = col_ff;
      emitting_in = emitting_ff;
      hrep_in     = hrep_ff;
      vrep_in     = vrep_ff;
      pad_in      = pad_ff;
      rows_in     = rows_ff;
      s1_meta_in  = s1_meta_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      produce     = 1'b0;
      le          = 1'b0;
      fill_nxt    = fill_ff;
      col_nxt     = col_ff;
      h_nxt       = {1'b0, hrep_ff} + (SCALE_W+1)'(1);
      v_nxt       = {1'b0, vrep_ff} + (SCALE_W+1)'(1);
      p_nxt       = {1'b0, pad_ff} + 3'd1;
      r_nxt       = {1'b0, rows_ff} + (HEIGHT_W+1)'(1);

      if (acc_load) begin
         if (emitting_ff) begin
            produce    = 1'b1;
            s1_meta_in = '{kind: KIND_REFUSED, line_end: 1'b0, image_end: 1'b0};
         end else begin
            mem_wr_en = CNT_W'(fill_ff) < MAX_W_CNT;
            if (CNT_W'(fill_ff) < width_eff) begin
               fill_nxt = fill_ff + FILL_W'(1);
            end
            fill_in = fill_nxt;
            if (CNT_W'(fill_nxt) >= width_eff) begin
               emitting_in = 1'b1;
            end
         end
      end else if (acc_pull) begin
         produce = 1'b1;
         if (!emitting_ff) begin
            s1_meta_in = '{kind: KIND_NONE, line_end: 1'b0, image_end: 1'b0};
         end else begin
            if (is_pix) begin
               mem_rd_en = 1'b1;
               if (h_nxt >= {1'b0, scale_eff}) begin
                  hrep_in = '0;
                  col_nxt = col_ff + FILL_W'(1);
               end else begin
                  hrep_in = h_nxt[SCALE_W-1:0];
               end
               col_in = col_nxt;
               le = (CNT_W'(col_nxt) >= width_eff) && (pad_ff >= pad_need);
               s1_meta_in.kind = KIND_PIXEL;
            end else begin
               pad_in = p_nxt[1:0];
               le = p_nxt >= {1'b0, pad_need};
               s1_meta_in.kind = KIND_PAD;
            end
            s1_meta_in.line_end  = le;
            s1_meta_in.image_end = 1'b0;
            if (le) begin
               col_in  = '0;
               hrep_in = '0;
               pad_in  = '0;
               if (v_nxt >= {1'b0, scale_eff}) begin
                  vrep_in     = '0;
                  emitting_in = 1'b0;
                  fill_in     = '0;
                  if (r_nxt >= {1'b0, height_eff}) begin
                     rows_in              = '0;
                     s1_meta_in.image_end = 1'b1;
                  end else begin
                     rows_in = r_nxt[HEIGHT_W-1:0];
                  end
               end else begin
                  vrep_in = v_nxt[SCALE_W-1:0];
               end
            end
         end
      end

      if (produce) begin
         s1_valid_in = 1'b1;
      end else if (s1_take) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         col_ff      <= '0;
         emitting_ff <= 1'b0;
         hrep_ff     <= '0;
         vrep_ff     <= '0;
         pad_ff      <= '0;
         rows_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         col_ff      <= col_in;
         emitting_ff <= emitting_in;
         hrep_ff     <= hrep_in;
         vrep_ff     <= vrep_in;
         pad_ff      <= pad_in;
         rows_ff     <= rows_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff <= s1_meta_in;
   end

   assign mem_wr_addr = fill_ff[ADDR_W-1:0];
   assign mem_wr_data = req_tdata;
   assign mem_rd_addr = col_ff[ADDR_W-1:0];
   assign s1_valid    = s1_valid_ff;
   assign s1_meta     = s1_meta_ff;

   `PRU_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !s1_take, s1_valid_ff && $stable(s1_meta_ff), "stalled result changed")
   `PRU_ASSERT_NEXT(a_refuse, acc_load && emitting_ff, s1_valid_ff && (s1_meta_ff.kind == KIND_REFUSED) && $stable(fill_ff), "load during emission not refused")
   `PRU_ASSERT_NEXT(a_idle_pull, acc_pull && !emitting_ff, s1_valid_ff && (s1_meta_ff.kind == KIND_NONE) && $stable(col_ff), "idle pull not reported")
   `PRU_ASSERT_SAME(a_image_line, s1_valid_ff && s1_meta_ff.image_end, s1_meta_ff.line_end, "image end without line end")

endmodule

[rtl/pru_out_stage.sv]
// result output register between the line store and the result channel
`timescale 1ns / 1ps
module pru_out_stage
   import pru_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic s1_valid,
   input  rsp_meta_type s1_meta,
   input  logic [PIX_W-1:0] rd_data,
   output logic s1_take,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [PIX_W-1:0] rsp_tdata,
   output logic [KIND_W:0] rsp_tuser,
   output logic rsp_tlast
);

   logic               out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]   out_pix_ff, out_pix_in;
   rsp_meta_type       out_meta_ff;

   assign s1_take = s1_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      if (s1_take) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      out_pix_in = (s1_meta.kind == KIND_PIXEL) ? rd_data : {3{PAD_BYTE}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         out_pix_ff  <= out_pix_in;
         out_meta_ff <= s1_meta;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tuser  = {out_meta_ff.image_end, out_meta_ff.kind};
   assign rsp_tlast  = out_meta_ff.line_end;

endmodule

[rtl/pixel_replicate_upscaler_core.sv]
// top level of the pixel replicate upscaler with its register port
// Integer nearest-neighbor upscaler for 24-bit pixels, one row at a time.
// req: tuser selects load (0) or pull (1); tdata carries the pixel on load.
// A load writes the next column of the line store; once the row holds
// in_width pixels, each pull returns the next output beat: a replicated
// pixel, a zero pad byte (lines padded to a multiple of four bytes), or a
// status beat (nothing ready, or pixel refused on a load while emitting).
// rsp: tlast marks the last beat of an output line, tuser[2] the last beat
// of the image. csr: scale_factor, in_width, in_height at 0x0, 0x4, 0x8.
// A load gives a beat only if refused; beats pass the s1 and out registers.
// Throughput: one item per cycle unless stalled; at most one line store
// access per item (one write port, one registered read port) plus counters.
// The output register lets one more item in while a beat waits on a stall;
// with both stages full req_tready drops until rsp_tready returns.
// Reset clears all counters and sets the three registers to 1; the line
// store needs no clearing pass, entries are always written before read.
`timescale 1ns / 1ps
module pixel_replicate_upscaler_core
   import pru_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [PIX_W-1:0] req_tdata,    // red, green, blue
   input  logic req_tuser,                // func
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [PIX_W-1:0] rsp_tdata,    // out_red, out_green, out_blue
   output logic [KIND_W:0] rsp_tuser,     // kind, image_end
   output logic rsp_tlast,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   cfg_type          cfg_ff, cfg_in;
   logic             csr_wr;
   logic             s1_take, s1_valid;
   rsp_meta_type     s1_meta;
   logic             mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [PIX_W-1:0] mem_wr_data, mem_rd_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_SCALE:  cfg_in.scale  = csr_pwdata[SCALE_W-1:0];
            REG_WIDTH:  cfg_in.width  = csr_pwdata[WIDTH_W-1:0];
            REG_HEIGHT: cfg_in.height = csr_pwdata[HEIGHT_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SCALE:  csr_prdata = {{(CSR_DATA_W-SCALE_W){1'b0}}, cfg_ff.scale};
         REG_WIDTH:  csr_prdata = {{(CSR_DATA_W-WIDTH_W){1'b0}}, cfg_ff.width};
         REG_HEIGHT: csr_prdata = {{(CSR_DATA_W-HEIGHT_W){1'b0}}, cfg_ff.height};
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{scale: SCALE_W'(1), width: WIDTH_W'(1), height: HEIGHT_W'(1)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pru_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .s1_take     (s1_take),
      .s1_valid    (s1_valid),
      .s1_meta     (s1_meta),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr)
   );

   pru_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pru_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_meta    (s1_meta),
      .rd_data    (mem_rd_data),
      .s1_take    (s1_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
